### hw/rtl/clsr_pkg.sv
// Shared types and constants of the character LCD shadow buffer refresh core.
package clsr_pkg;

	localparam logic [2:0] MODE_PLACE_CHAR = 3'd0;
	localparam logic [2:0] MODE_PUT_CHAR   = 3'd1;
	localparam logic [2:0] MODE_PLACE_NUM  = 3'd2;
	localparam logic [2:0] MODE_CLEAR      = 3'd3;
	localparam logic [2:0] MODE_REFRESH    = 3'd4;

	localparam int unsigned COL_W      = 4;
	localparam int unsigned NUM_W      = 25;
	localparam int unsigned MAG_W      = 24;
	localparam int unsigned BCD_DIGITS = 7;
	localparam int unsigned BCD_W      = 4 * BCD_DIGITS;

	localparam logic [MAG_W-1:0] NUM_MAX = 24'd9999999;

	localparam logic [7:0] CHAR_SPACE  = 8'h20;
	localparam logic [7:0] CHAR_ZERO   = 8'h30;
	localparam logic [7:0] CHAR_MINUS  = 8'h2D;
	localparam logic [7:0] CMD_DDRAM   = 8'h80;
	localparam logic [7:0] ROW2_OFFSET = 8'h40;
	localparam logic [7:0] DDRAM_MASK  = 8'h7F;

	typedef enum logic [2:0] {
		OP_PLACE_CHAR,
		OP_PUT_CHAR,
		OP_PLACE_NUM,
		OP_CLEAR,
		OP_REFRESH
	} clsr_op_t;

	typedef struct packed {
		clsr_op_t         op;
		logic             row;
		logic [COL_W-1:0] col;
		logic [7:0]       char_code;
		logic             neg;
		logic [BCD_W-1:0] bcd;
	} clsr_cmd_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_CONV,
		F_PUSH
	} clsr_fstate_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_NUM,
		B_CMD,
		B_DATA
	} clsr_bstate_t;

endpackage

### hw/rtl/clsr_ram.sv
// Generic single write port RAM with a registered, enabled read port.
module clsr_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### hw/rtl/clsr_fifo.sv
// Short command queue between the front and back parts.
module clsr_fifo #(
	parameter int unsigned DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  clsr_pkg::clsr_cmd_t  push_cmd,
	output logic                 full,
	input  logic                 pop,
	output clsr_pkg::clsr_cmd_t  pop_cmd,
	output logic                 empty
);

	import clsr_pkg::*;

	localparam int unsigned PW   = $clog2(DEPTH);
	localparam int unsigned CNTW = $clog2(DEPTH + 1);

	clsr_cmd_t        mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CNTW-1:0]  count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNTW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign pop_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CNTW'(1);
				2'b01:   count_q <= count_q - CNTW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### hw/rtl/clsr_front.sv
// Front part: accepts items, decodes them and converts numbers to decimal digits.
module clsr_front #(
	parameter int unsigned COLUMNS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_ready,
	input  logic [2:0]                        mode,
	input  logic                              row,
	input  logic [clsr_pkg::COL_W-1:0]        col,
	input  logic [7:0]                        char_code,
	input  logic signed [clsr_pkg::NUM_W-1:0] number,
	input  logic                              q_full,
	output logic                              q_push,
	output clsr_pkg::clsr_cmd_t               q_cmd
);

	import clsr_pkg::*;

	localparam int unsigned STEP_W = $clog2(MAG_W);

	clsr_fstate_t      state_q;
	clsr_fstate_t      state_d;
	clsr_cmd_t         cmd_q;
	clsr_cmd_t         dec_cmd;
	logic              dec_keep;
	logic              accept;
	logic [COL_W-1:0]  col_mod;
	logic [NUM_W-1:0]  num_bits;
	logic [NUM_W-1:0]  mag_raw;
	logic [MAG_W-1:0]  mag_sat;
	logic [MAG_W-1:0]  bin_q;
	logic [BCD_W-1:0]  bcd_q;
	logic [BCD_W-1:0]  bcd_adj;
	logic [STEP_W-1:0] step_q;

	// Column wraps modulo the row length; one subtract is enough for a 4-bit column.
	always_comb begin
		if (32'(col) >= COLUMNS) begin
			col_mod = col - COL_W'(COLUMNS);
		end else begin
			col_mod = col;
		end
	end

	always_comb begin
		num_bits = number;
		mag_raw  = num_bits[NUM_W-1] ? (~num_bits + NUM_W'(1)) : num_bits;
		mag_sat  = (mag_raw > {1'b0, NUM_MAX}) ? NUM_MAX : mag_raw[MAG_W-1:0];
	end

	always_comb begin
		dec_keep          = 1'b1;
		dec_cmd.op        = OP_PLACE_CHAR;
		dec_cmd.row       = row;
		dec_cmd.col       = col_mod;
		dec_cmd.char_code = char_code;
		dec_cmd.neg       = num_bits[NUM_W-1];
		dec_cmd.bcd       = '0;
		unique case (mode)
			MODE_PLACE_CHAR: dec_cmd.op = OP_PLACE_CHAR;
			MODE_PUT_CHAR:   dec_cmd.op = OP_PUT_CHAR;
			MODE_PLACE_NUM:  dec_cmd.op = OP_PLACE_NUM;
			MODE_CLEAR:      dec_cmd.op = OP_CLEAR;
			MODE_REFRESH:    dec_cmd.op = OP_REFRESH;
			default:         dec_keep   = 1'b0;
		endcase
	end

	// Double dabble: every digit of five or more gets three added before the shift.
	always_comb begin
		bcd_adj = bcd_q;
		for (int i = 0; i < BCD_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end
		end
	end

	assign accept = item_valid && item_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			F_IDLE: begin
				if (accept && dec_keep && (dec_cmd.op == OP_PLACE_NUM)) begin
					state_d = F_CONV;
				end
			end
			F_CONV: begin
				if (step_q == STEP_W'(MAG_W - 1)) begin
					state_d = F_PUSH;
				end
			end
			F_PUSH: begin
				if (!q_full) begin
					state_d = F_IDLE;
				end
			end
			default: state_d = F_IDLE;
		endcase
	end

	always_comb begin
		item_ready = 1'b0;
		q_push     = 1'b0;
		q_cmd      = cmd_q;
		q_cmd.bcd  = bcd_q;
		unique case (state_q)
			F_IDLE: begin
				item_ready = !q_full;
				q_push     = item_valid && !q_full && dec_keep && (dec_cmd.op != OP_PLACE_NUM);
				q_cmd      = dec_cmd;
			end
			F_CONV: begin
				q_push = 1'b0;
			end
			F_PUSH: begin
				q_push = !q_full;
			end
			default: begin
				q_push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= dec_cmd;
			bin_q  <= mag_sat;
			bcd_q  <= '0;
			step_q <= '0;
		end else if (state_q == F_CONV) begin
			{bcd_q, bin_q} <= {bcd_adj[BCD_W-2:0], bin_q, 1'b0};
			step_q         <= step_q + STEP_W'(1);
		end
	end

endmodule

### hw/rtl/clsr_back.sv
// Back part: updates the shadow buffer and cursor and sends refresh bursts.
module clsr_back #(
	parameter int unsigned COLUMNS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                refresh_half_rows,
	input  logic                q_empty,
	input  clsr_pkg::clsr_cmd_t q_cmd,
	output logic                q_pop,
	output logic                byte_valid,
	input  logic                byte_ready,
	output logic [7:0]          lcd_byte,
	output logic                is_command,
	output logic                last
);

	import clsr_pkg::*;

	localparam int unsigned DEPTH = 2 * COLUMNS;
	localparam int unsigned AW    = $clog2(DEPTH);
	localparam int unsigned CW    = $clog2(COLUMNS + 1);
	localparam int unsigned DCW   = $clog2(BCD_DIGITS + 1);
	localparam int unsigned LEFT  = COLUMNS / 2;
	localparam int unsigned RIGHT = COLUMNS - COLUMNS / 2;
	localparam logic [AW-1:0] ROW_BASE = AW'(COLUMNS);
	localparam logic [CW-1:0] COL_END  = CW'(COLUMNS);

	clsr_bstate_t     state_q;
	clsr_bstate_t     state_d;
	logic             cur_row_q;
	logic [CW-1:0]    cur_col_q;
	logic [1:0]       phase_q;
	logic [7:0]       fill_q;
	logic [DEPTH-1:0] vld_q;
	logic             num_neg_q;
	logic             num_started_q;
	logic [BCD_W-1:0] num_bcd_q;
	logic [DCW-1:0]   num_cnt_q;
	logic [7:0]       cmd_byte_q;
	logic [AW-1:0]    rd_addr_q;
	logic [CW-1:0]    rd_left_q;
	logic [CW-1:0]    mv_left_q;
	logic             rd_pend_q;
	logic             rd_vld_q;
	logic             byte_valid_q;
	logic [7:0]       lcd_byte_q;
	logic             is_command_q;
	logic             last_q;

	logic             brst_skip;
	logic             brst_row;
	logic [CW-1:0]    brst_col;
	logic [CW-1:0]    brst_len;
	logic [1:0]       phase_nxt;
	logic [7:0]       ddram_addr;
	logic [7:0]       brst_cmd;
	logic [AW-1:0]    brst_addr;
	logic             cur_room;
	logic [AW-1:0]    cur_addr;
	logic [AW-1:0]    place_addr;
	logic [3:0]       num_digit;
	logic             num_emit;
	logic [7:0]       num_char;
	logic             out_free;
	logic             move;
	logic             dispatch;
	logic             ram_we;
	logic             ram_re;
	logic [AW-1:0]    ram_waddr;
	logic [7:0]       ram_wdata;
	logic [7:0]       ram_rdata;
	logic             out_load;
	logic [7:0]       out_byte;
	logic             out_cmd;
	logic             out_last;

	clsr_ram #(
		.WIDTH (8),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (rd_addr_q),
		.rdata (ram_rdata)
	);

	// Row mode only knows phases zero and one; a leftover phase sends nothing.
	always_comb begin
		brst_skip = 1'b0;
		brst_row  = 1'b0;
		brst_col  = '0;
		brst_len  = COL_END;
		phase_nxt = 2'd0;
		if (refresh_half_rows) begin
			if (phase_q[1]) begin
				brst_skip = 1'b1;
			end else begin
				brst_row  = phase_q[0];
				phase_nxt = {1'b0, ~phase_q[0]};
			end
		end else begin
			brst_row  = phase_q[1];
			brst_col  = phase_q[0] ? CW'(LEFT) : '0;
			brst_len  = phase_q[0] ? CW'(RIGHT) : CW'(LEFT);
			phase_nxt = phase_q + 2'd1;
		end
		ddram_addr = (brst_row ? ROW2_OFFSET : 8'h00) + 8'(brst_col);
		brst_cmd   = CMD_DDRAM | (ddram_addr & DDRAM_MASK);
		brst_addr  = (brst_row ? ROW_BASE : '0) + AW'(brst_col);
	end

	always_comb begin
		cur_room   = (cur_col_q < COL_END);
		cur_addr   = (cur_row_q ? ROW_BASE : '0) + AW'(cur_col_q);
		place_addr = (q_cmd.row ? ROW_BASE : '0) + AW'(q_cmd.col);
		num_digit  = num_bcd_q[BCD_W-1 -: 4];
		num_emit   = num_neg_q || (num_digit != 4'd0) || num_started_q
			|| (num_cnt_q == DCW'(1));
		num_char   = num_neg_q ? CHAR_MINUS : (CHAR_ZERO + {4'h0, num_digit});
		out_free   = !byte_valid_q || byte_ready;
		move       = (state_q == B_DATA) && rd_pend_q && out_free;
		dispatch   = (state_q == B_IDLE) && !q_empty;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (!q_empty) begin
					if (q_cmd.op == OP_PLACE_NUM) begin
						state_d = B_NUM;
					end else if ((q_cmd.op == OP_REFRESH) && !brst_skip) begin
						state_d = B_CMD;
					end
				end
			end
			B_NUM: begin
				if (!num_neg_q && (num_cnt_q == DCW'(1))) begin
					state_d = B_IDLE;
				end
			end
			B_CMD: begin
				if (out_free) begin
					state_d = B_DATA;
				end
			end
			B_DATA: begin
				if (move && (mv_left_q == CW'(1))) begin
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		q_pop     = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = cur_addr;
		ram_wdata = num_char;
		ram_re    = 1'b0;
		out_load  = 1'b0;
		out_byte  = cmd_byte_q;
		out_cmd   = 1'b1;
		out_last  = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				q_pop = !q_empty;
				if (!q_empty && (q_cmd.op == OP_PLACE_CHAR)) begin
					ram_we    = 1'b1;
					ram_waddr = place_addr;
					ram_wdata = q_cmd.char_code;
				end else if (!q_empty && (q_cmd.op == OP_PUT_CHAR)) begin
					ram_we    = cur_room;
					ram_wdata = q_cmd.char_code;
				end
			end
			B_NUM: begin
				ram_we = num_emit && cur_room;
			end
			B_CMD: begin
				out_load = out_free;
			end
			B_DATA: begin
				ram_re   = (rd_left_q != '0) && (!rd_pend_q || out_free);
				out_load = move;
				out_byte = rd_vld_q ? ram_rdata : fill_q;
				out_cmd  = 1'b0;
				out_last = (mv_left_q == CW'(1));
			end
			default: begin
				q_pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= B_IDLE;
			cur_row_q     <= 1'b0;
			cur_col_q     <= '0;
			phase_q       <= 2'd0;
			fill_q        <= 8'h00;
			vld_q         <= '0;
			num_neg_q     <= 1'b0;
			num_started_q <= 1'b0;
			num_cnt_q     <= '0;
			rd_left_q     <= '0;
			mv_left_q     <= '0;
			rd_pend_q     <= 1'b0;
			byte_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (dispatch) begin
				unique case (q_cmd.op)
					OP_PLACE_CHAR: begin
						cur_row_q          <= q_cmd.row;
						cur_col_q          <= CW'(q_cmd.col);
						vld_q[place_addr]  <= 1'b1;
					end
					OP_PUT_CHAR: begin
						if (cur_room) begin
							cur_col_q        <= cur_col_q + CW'(1);
							vld_q[cur_addr]  <= 1'b1;
						end
					end
					OP_PLACE_NUM: begin
						cur_row_q     <= q_cmd.row;
						cur_col_q     <= CW'(q_cmd.col);
						num_neg_q     <= q_cmd.neg;
						num_started_q <= 1'b0;
						num_cnt_q     <= DCW'(BCD_DIGITS);
					end
					OP_CLEAR: begin
						vld_q  <= '0;
						fill_q <= CHAR_SPACE;
					end
					OP_REFRESH: begin
						phase_q   <= phase_nxt;
						rd_left_q <= brst_len;
						mv_left_q <= brst_len;
					end
					default: begin
						phase_q <= phase_q;
					end
				endcase
			end
			if (state_q == B_NUM) begin
				if (num_emit && cur_room) begin
					cur_col_q       <= cur_col_q + CW'(1);
					vld_q[cur_addr] <= 1'b1;
				end
				if (num_neg_q) begin
					num_neg_q <= 1'b0;
				end else begin
					num_cnt_q     <= num_cnt_q - DCW'(1);
					num_started_q <= num_started_q || (num_digit != 4'd0);
				end
			end
			if (ram_re) begin
				rd_left_q <= rd_left_q - CW'(1);
				rd_pend_q <= 1'b1;
			end else if (move) begin
				rd_pend_q <= 1'b0;
			end
			if (move) begin
				mv_left_q <= mv_left_q - CW'(1);
			end
			if (out_load) begin
				byte_valid_q <= 1'b1;
			end else if (byte_ready) begin
				byte_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dispatch && (q_cmd.op == OP_PLACE_NUM)) begin
			num_bcd_q <= q_cmd.bcd;
		end else if ((state_q == B_NUM) && !num_neg_q) begin
			num_bcd_q <= {num_bcd_q[BCD_W-5:0], 4'h0};
		end
		if (dispatch && (q_cmd.op == OP_REFRESH)) begin
			cmd_byte_q <= brst_cmd;
			rd_addr_q  <= brst_addr;
		end else if (ram_re) begin
			rd_addr_q <= rd_addr_q + AW'(1);
		end
		if (ram_re) begin
			rd_vld_q <= vld_q[rd_addr_q];
		end
		if (out_load) begin
			lcd_byte_q   <= out_byte;
			is_command_q <= out_cmd;
			last_q       <= out_last;
		end
	end

	assign byte_valid = byte_valid_q;
	assign lcd_byte   = lcd_byte_q;
	assign is_command = is_command_q;
	assign last       = last_q;

endmodule

### hw/rtl/char_lcd_shadow_refresh_core.sv
// Top level of the character LCD shadow buffer refresh core.
// Usage: items arrive on the item channel (item_valid/item_ready) and carry a mode,
// a row and column, a character and a signed number. Place char, char at cursor and
// clear update the two-row shadow buffer; place number writes its decimal text at
// the given position; a refresh tick sends one burst on the byte channel
// (byte_valid/byte_ready): a set-DDRAM-address command, then the data bytes of one
// half row or one full row, the final byte marked by last.
// The configuration channel (cfg_valid/cfg_ready/cfg_data) writes the refresh layout
// bit; write it only while the core is idle. cfg_ready is always high.
// Flow: the front takes an item and queues a non-number item in the same cycle; after a
// number, item_ready stays low while the binary to decimal converter runs and until it is queued.
// The back executes a character write or a clear as it dispatches the command, a number as a
// dispatch step, one step per digit and one for a minus sign, and a burst as a command byte
// and then the data bytes, one buffer read per cycle when the receiver keeps up. A queue of
// QUEUE_DEPTH commands lets the front keep accepting items while the back is busy.
// Reset: the buffer reads as zero bytes, cursor and refresh phase are zero and the
// quarter layout is selected; no clearing pass is needed.
// A stalled byte channel holds the current byte; the back pauses, and once the queue
// fills, item_ready drops.
module char_lcd_shadow_refresh_core #(
	parameter int unsigned COLUMNS     = 16,
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic                              cfg_data,
	input  logic                              item_valid,
	output logic                              item_ready,
	input  logic [2:0]                        mode,
	input  logic                              row,
	input  logic [clsr_pkg::COL_W-1:0]        col,
	input  logic [7:0]                        char_code,
	input  logic signed [clsr_pkg::NUM_W-1:0] number,
	output logic                              byte_valid,
	input  logic                              byte_ready,
	output logic [7:0]                        lcd_byte,
	output logic                              is_command,
	output logic                              last
);

	import clsr_pkg::*;

	logic      refresh_half_rows_q;
	logic      q_push;
	logic      q_full;
	logic      q_pop;
	logic      q_empty;
	clsr_cmd_t push_cmd;
	clsr_cmd_t pop_cmd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			refresh_half_rows_q <= 1'b0;
		end else if (cfg_valid) begin
			refresh_half_rows_q <= cfg_data;
		end
	end

	clsr_front #(
		.COLUMNS (COLUMNS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.mode       (mode),
		.row        (row),
		.col        (col),
		.char_code  (char_code),
		.number     (number),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_cmd      (push_cmd)
	);

	clsr_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.pop_cmd  (pop_cmd),
		.empty    (q_empty)
	);

	clsr_back #(
		.COLUMNS (COLUMNS)
	) u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.refresh_half_rows (refresh_half_rows_q),
		.q_empty           (q_empty),
		.q_cmd             (pop_cmd),
		.q_pop             (q_pop),
		.byte_valid        (byte_valid),
		.byte_ready        (byte_ready),
		.lcd_byte          (lcd_byte),
		.is_command        (is_command),
		.last              (last)
	);

endmodule

### hw/rtl/clsr_checker.sv
// Port checker for the refresh core, bound to the top level.
module clsr_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       byte_valid,
	input logic       byte_ready,
	input logic [7:0] lcd_byte,
	input logic       is_command,
	input logic       last
);

	logic burst_open_q;

	// A burst stays open from its command word until the word marked last is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			burst_open_q <= 1'b0;
		end else if (byte_valid && byte_ready) begin
			burst_open_q <= !last;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && !byte_ready |=> byte_valid && $stable(lcd_byte)
			&& $stable(is_command) && $stable(last))
		else $error("Stalled output word changed.");

	a_cmd_addr: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && is_command |-> lcd_byte[7])
		else $error("Command word is not a set-address command.");

	a_cmd_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && is_command |-> !last)
		else $error("Burst ended on its command word.");

	a_burst_start: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && !burst_open_q |-> is_command)
		else $error("Burst did not start with a command word.");

	a_burst_body: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && burst_open_q |-> !is_command)
		else $error("Command word inside a burst.");

endmodule

bind char_lcd_shadow_refresh_core clsr_checker u_checker (.*);
